FILE: sv/gdn_pkg.sv
// shared types and constants for the gregorian day number converter
// no dependencies; used by every other file of the block
`timescale 1ns / 1ps

package gdn_pkg;

   // pipeline depth, one valid bit per stage
   localparam int NUM_STAGES = 10;

   // operation codes carried in the func field
   localparam logic FUNC_TO_DAY  = 1'b0;
   localparam logic FUNC_TO_DATE = 1'b1;

   // day number constants
   localparam logic [22:0] JDN_BASE = 23'd1721119;
   localparam logic [22:0] JDN_MIN  = 23'd1721120;
   localparam logic [22:0] JDN_MAX  = 23'd5373484;

   // days in 400 years and in 4 years
   localparam logic [17:0] DAYS_400Y = 18'd146097;
   localparam logic [10:0] DAYS_4Y   = 11'd1461;

   typedef struct packed {
      logic        func;
      logic [13:0] year_in;
      logic [3:0]  month_in;
      logic [4:0]  mday_in;
      logic [22:0] day_number_in;
   } req_word_type;

   typedef struct packed {
      logic [22:0] day_number_out;
      logic [2:0]  weekday_out;
      logic [13:0] year_out;
      logic [3:0]  month_out;
      logic [4:0]  mday_out;
      logic        error;
   } rsp_word_type;

   // one load enable per pipeline stage
   typedef logic [NUM_STAGES-1:0] stage_en_type;

endpackage

FILE: sv/gdn_date_to_day.sv
// date to day number and weekday datapath, ten register stages
// depends on gdn_pkg
`timescale 1ns / 1ps

module gdn_date_to_day (
   input  logic                 clock,
   input  gdn_pkg::stage_en_type stage_en,
   input  logic [13:0]          year,
   input  logic [3:0]           month,
   input  logic [4:0]           mday,
   output logic [22:0]          day_number,
   output logic [2:0]           weekday,
   output logic                 error
);

   localparam logic [13:0] YEAR_FLOOR = 14'd1000;
   // floor(2^14 / 100); estimate is low by at most one
   localparam int          K100       = 14;
   localparam logic [7:0]  RECIP_100  = 8'((32'd1 << K100) / 32'd100);
   localparam logic [6:0]  CENT_DAYS  = 7'd100;

   // days from march 1 to the first of the month, march-based month index
   function automatic logic [8:0] month_offset(input logic [3:0] mm);
      logic [8:0] days;
      case (mm)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd31;
         4'd2:    days = 9'd61;
         4'd3:    days = 9'd92;
         4'd4:    days = 9'd122;
         4'd5:    days = 9'd153;
         4'd6:    days = 9'd184;
         4'd7:    days = 9'd214;
         4'd8:    days = 9'd245;
         4'd9:    days = 9'd275;
         4'd10:   days = 9'd306;
         4'd11:   days = 9'd337;
         4'd12:   days = 9'd367;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

   // stage registers
   logic [13:0] y_s0_ff, y_s1_ff;
   logic [3:0]  mm_s0_ff, mm_s1_ff, mm_s2_ff;
   logic [4:0]  mday_s0_ff, mday_s1_ff, mday_s2_ff, mday_s3_ff;
   logic [9:0]  err_ff;
   logic [21:0] prod_s1_ff;
   logic [7:0]  q0_s2_ff;
   logic [7:0]  rem_s2_ff;
   logic [7:0]  cent_s3_ff;
   logic [6:0]  yoc_s3_ff;
   logic [8:0]  moff_s3_ff;
   logic [22:0] a4_s4_ff;
   logic [15:0] b4_s4_ff;
   logic [20:0] c_s4_ff, c_s5_ff;
   logic [22:0] sum_s5_ff;
   logic [22:0] dn_s6_ff, dn_s7_ff, dn_s8_ff, dn_s9_ff;
   logic [5:0]  dsum_s7_ff;
   logic [3:0]  fold_s8_ff;
   logic [2:0]  wd_s9_ff;

   // next values
   logic [13:0] y_in;
   logic [3:0]  mm_in;
   logic [21:0] prod_in;
   logic [7:0]  rem_in;
   logic [7:0]  cent_in;
   logic [6:0]  yoc_in;
   logic [25:0] a_in;
   logic [17:0] b_in;
   logic [20:0] c_in;
   logic [22:0] sum_in;
   logic [22:0] dn_in;
   logic [5:0]  dsum_in;
   logic [3:0]  fold_in;
   logic [2:0]  wd_in;

   // january and february belong to the previous march-based year
   always_comb begin
      if (month > 4'd2) begin
         y_in  = year;
         mm_in = 4'(month - 4'd3);
      end else begin
         y_in  = 14'(year - 14'd1);
         mm_in = 4'(month + 4'd9);
      end
   end

   assign prod_in = 22'(y_s0_ff) * 22'(RECIP_100);
   assign rem_in  = 8'(y_s1_ff - 14'(prod_s1_ff[21:K100]) * 14'(CENT_DAYS));

   // one correction step finishes year / 100 and year % 100
   always_comb begin
      if (rem_s2_ff >= 8'(CENT_DAYS)) begin
         cent_in = 8'(q0_s2_ff + 8'd1);
         yoc_in  = 7'(rem_s2_ff - 8'(CENT_DAYS));
      end else begin
         cent_in = q0_s2_ff;
         yoc_in  = rem_s2_ff[6:0];
      end
   end

   assign a_in   = 26'(cent_s3_ff) * 26'(gdn_pkg::DAYS_400Y);
   assign b_in   = 18'(yoc_s3_ff) * 18'(gdn_pkg::DAYS_4Y);
   assign c_in   = 21'(gdn_pkg::JDN_BASE) + 21'(mday_s3_ff) + 21'(moff_s3_ff);
   assign sum_in = a4_s4_ff + 23'(b4_s4_ff);
   assign dn_in  = err_ff[5] ? 23'd0 : 23'(sum_s5_ff + 23'(c_s5_ff));

   // 8 = 1 mod 7, so the octal digit sum keeps the remainder
   always_comb begin
      logic [23:0] dn_pad;
      dn_pad  = {1'b0, dn_s6_ff};
      dsum_in = '0;
      for (int i = 0; i < 8; i++) begin
         dsum_in = dsum_in + 6'(dn_pad[3*i +: 3]);
      end
   end

   assign fold_in = 4'(dsum_s7_ff[5:3]) + 4'(dsum_s7_ff[2:0]);

   always_comb begin
      if (fold_s8_ff >= 4'd14) begin
         wd_in = 3'd1;
      end else if (fold_s8_ff >= 4'd7) begin
         wd_in = 3'(fold_s8_ff - 4'd6);
      end else begin
         wd_in = 3'(fold_s8_ff + 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         y_s0_ff    <= y_in;
         mm_s0_ff   <= mm_in;
         mday_s0_ff <= mday;
         err_ff[0]  <= (year <= YEAR_FLOOR);
      end
      if (stage_en[1]) begin
         prod_s1_ff <= prod_in;
         y_s1_ff    <= y_s0_ff;
         mm_s1_ff   <= mm_s0_ff;
         mday_s1_ff <= mday_s0_ff;
         err_ff[1]  <= err_ff[0];
      end
      if (stage_en[2]) begin
         q0_s2_ff   <= prod_s1_ff[21:K100];
         rem_s2_ff  <= rem_in;
         mm_s2_ff   <= mm_s1_ff;
         mday_s2_ff <= mday_s1_ff;
         err_ff[2]  <= err_ff[1];
      end
      if (stage_en[3]) begin
         cent_s3_ff <= cent_in;
         yoc_s3_ff  <= yoc_in;
         moff_s3_ff <= month_offset(mm_s2_ff);
         mday_s3_ff <= mday_s2_ff;
         err_ff[3]  <= err_ff[2];
      end
      if (stage_en[4]) begin
         a4_s4_ff  <= a_in[24:2];
         b4_s4_ff  <= b_in[17:2];
         c_s4_ff   <= c_in;
         err_ff[4] <= err_ff[3];
      end
      if (stage_en[5]) begin
         sum_s5_ff <= sum_in;
         c_s5_ff   <= c_s4_ff;
         err_ff[5] <= err_ff[4];
      end
      if (stage_en[6]) begin
         dn_s6_ff  <= dn_in;
         err_ff[6] <= err_ff[5];
      end
      if (stage_en[7]) begin
         dsum_s7_ff <= dsum_in;
         dn_s7_ff   <= dn_s6_ff;
         err_ff[7]  <= err_ff[6];
      end
      if (stage_en[8]) begin
         fold_s8_ff <= fold_in;
         dn_s8_ff   <= dn_s7_ff;
         err_ff[8]  <= err_ff[7];
      end
      if (stage_en[9]) begin
         wd_s9_ff  <= wd_in;
         dn_s9_ff  <= dn_s8_ff;
         err_ff[9] <= err_ff[8];
      end
   end

   assign day_number = dn_s9_ff;
   assign weekday    = wd_s9_ff;
   assign error      = err_ff[9];

endmodule

FILE: sv/gdn_day_to_date.sv
// day number to date datapath, ten register stages
// depends on gdn_pkg
`timescale 1ns / 1ps

module gdn_day_to_date (
   input  logic                 clock,
   input  gdn_pkg::stage_en_type stage_en,
   input  logic [22:0]          day_number,
   output logic [13:0]          year,
   output logic [3:0]           month,
   output logic [4:0]           mday,
   output logic                 error
);

   // reciprocals floor(2^k / d); each estimate is low by at most one
   localparam int          K400       = 24;
   localparam logic [6:0]  RECIP_400Y = 7'((32'd1 << K400) / 32'd146097);
   localparam int          K4Y        = 18;
   localparam logic [7:0]  RECIP_4Y   = 8'((32'd1 << K4Y) / 32'd1461);
   localparam int          K153       = 11;
   localparam logic [3:0]  RECIP_153  = 4'((32'd1 << K153) / 32'd153);
   // ceil(2^10 / 5), exact below 1024
   localparam int          K5         = 10;
   localparam logic [7:0]  RECIP_5    = 8'(((32'd1 << K5) + 32'd4) / 32'd5);
   localparam logic [7:0]  DAYS_5M    = 8'd153;
   localparam logic [24:0] N1_OFFSET  = 25'(4 * 1721119 + 1);

   // stage registers
   logic [23:0] n1_s0_ff, n1_s1_ff;
   logic [9:0]  err_ff;
   logic [30:0] prod1_s1_ff;
   logic [6:0]  cy0_s2_ff;
   logic [18:0] rem1_s2_ff;
   logic [6:0]  cy_s3_ff;
   logic [17:0] n2_s3_ff, n2_s4_ff;
   logic [25:0] prod2_s4_ff;
   logic [13:0] cent_s4_ff, cent_s5_ff;
   logic [7:0]  q2_s5_ff;
   logic [11:0] rem2_s5_ff;
   logic [13:0] yr_s6_ff, yr_s7_ff, yr_s8_ff;
   logic [10:0] r2_s6_ff;
   logic [10:0] n3_s7_ff;
   logic [14:0] prod3_s7_ff;
   logic [3:0]  mo0_s8_ff;
   logic [8:0]  rem3_s8_ff;
   logic [13:0] year_s9_ff;
   logic [3:0]  month_s9_ff;
   logic [4:0]  mday_s9_ff;

   // next values
   logic [23:0] n1_in;
   logic [30:0] prod1_in;
   logic [18:0] rem1_in;
   logic [6:0]  cy_in;
   logic [17:0] r1_in;
   logic [25:0] prod2_in;
   logic [13:0] cent_in;
   logic [11:0] rem2_in;
   logic [7:0]  j2_in;
   logic [10:0] r2_in;
   logic [10:0] n3_in;
   logic [14:0] prod3_in;
   logic [8:0]  rem3_in;
   logic [3:0]  mo_in;
   logic [7:0]  r3_in;
   logic [16:0] dq_in;
   logic [13:0] year_in;
   logic [3:0]  month_in;
   logic [4:0]  mday_in;

   assign n1_in    = 24'({day_number, 2'b00} - N1_OFFSET);
   assign prod1_in = 31'(n1_s0_ff) * 31'(RECIP_400Y);
   assign rem1_in  = 19'(25'(n1_s1_ff) - 25'(prod1_s1_ff[30:K400]) * 25'(gdn_pkg::DAYS_400Y));

   always_comb begin
      if (rem1_s2_ff >= 19'(gdn_pkg::DAYS_400Y)) begin
         cy_in = 7'(cy0_s2_ff + 7'd1);
         r1_in = 18'(rem1_s2_ff - 19'(gdn_pkg::DAYS_400Y));
      end else begin
         cy_in = cy0_s2_ff;
         r1_in = rem1_s2_ff[17:0];
      end
   end

   assign prod2_in = 26'(n2_s3_ff) * 26'(RECIP_4Y);
   assign cent_in  = 14'(cy_s3_ff) * 14'd100;
   assign rem2_in  = 12'(n2_s4_ff - 18'(prod2_s4_ff[25:K4Y]) * 18'(gdn_pkg::DAYS_4Y));

   always_comb begin
      if (rem2_s5_ff >= 12'(gdn_pkg::DAYS_4Y)) begin
         j2_in = 8'(q2_s5_ff + 8'd1);
         r2_in = 11'(rem2_s5_ff - 12'(gdn_pkg::DAYS_4Y));
      end else begin
         j2_in = q2_s5_ff;
         r2_in = rem2_s5_ff[10:0];
      end
   end

   // 5 * ((r2 + 4) / 4) - 3 folds to 5 * (r2 / 4) + 2
   assign n3_in    = 11'(11'(r2_s6_ff[10:2]) * 11'd5 + 11'd2);
   assign prod3_in = 15'(n3_in) * 15'(RECIP_153);
   assign rem3_in  = 9'(n3_s7_ff - 11'(prod3_s7_ff[14:K153]) * 11'(DAYS_5M));

   always_comb begin
      if (rem3_s8_ff >= 9'(DAYS_5M)) begin
         mo_in = 4'(mo0_s8_ff + 4'd1);
         r3_in = 8'(rem3_s8_ff - 9'(DAYS_5M));
      end else begin
         mo_in = mo0_s8_ff;
         r3_in = rem3_s8_ff[7:0];
      end
      dq_in = 17'(9'(r3_in) + 9'd5) * 17'(RECIP_5);
      // january and february close the march-based year
      if (mo_in < 4'd10) begin
         month_in = 4'(mo_in + 4'd3);
         year_in  = yr_s8_ff;
      end else begin
         month_in = 4'(mo_in - 4'd9);
         year_in  = 14'(yr_s8_ff + 14'd1);
      end
      mday_in = 5'(dq_in[16:K5]);
      if (err_ff[8]) begin
         month_in = '0;
         year_in  = '0;
         mday_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         n1_s0_ff  <= n1_in;
         err_ff[0] <= (day_number < gdn_pkg::JDN_MIN) || (day_number > gdn_pkg::JDN_MAX);
      end
      if (stage_en[1]) begin
         prod1_s1_ff <= prod1_in;
         n1_s1_ff    <= n1_s0_ff;
         err_ff[1]   <= err_ff[0];
      end
      if (stage_en[2]) begin
         cy0_s2_ff  <= prod1_s1_ff[30:K400];
         rem1_s2_ff <= rem1_in;
         err_ff[2]  <= err_ff[1];
      end
      if (stage_en[3]) begin
         cy_s3_ff  <= cy_in;
         n2_s3_ff  <= {r1_in[17:2], 2'b11};
         err_ff[3] <= err_ff[2];
      end
      if (stage_en[4]) begin
         prod2_s4_ff <= prod2_in;
         n2_s4_ff    <= n2_s3_ff;
         cent_s4_ff  <= cent_in;
         err_ff[4]   <= err_ff[3];
      end
      if (stage_en[5]) begin
         q2_s5_ff   <= prod2_s4_ff[25:K4Y];
         rem2_s5_ff <= rem2_in;
         cent_s5_ff <= cent_s4_ff;
         err_ff[5]  <= err_ff[4];
      end
      if (stage_en[6]) begin
         yr_s6_ff  <= 14'(cent_s5_ff + 14'(j2_in));
         r2_s6_ff  <= r2_in;
         err_ff[6] <= err_ff[5];
      end
      if (stage_en[7]) begin
         n3_s7_ff    <= n3_in;
         prod3_s7_ff <= prod3_in;
         yr_s7_ff    <= yr_s6_ff;
         err_ff[7]   <= err_ff[6];
      end
      if (stage_en[8]) begin
         mo0_s8_ff  <= prod3_s7_ff[14:K153];
         rem3_s8_ff <= rem3_in;
         yr_s8_ff   <= yr_s7_ff;
         err_ff[8]  <= err_ff[7];
      end
      if (stage_en[9]) begin
         year_s9_ff  <= year_in;
         month_s9_ff <= month_in;
         mday_s9_ff  <= mday_in;
         err_ff[9]   <= err_ff[8];
      end
   end

   assign year  = year_s9_ff;
   assign month = month_s9_ff;
   assign mday  = mday_s9_ff;
   assign error = err_ff[9];

endmodule

FILE: sv/gregorian_day_number_converter.sv
// ten register stages; rsp_valid is the valid bit of the last stage, set once an accepted req word reaches it
// throughput: one word per cycle, sustained as long as rsp_ready stays high
// ready ripples back through the ten stage valid bits; an empty stage is always ready
// reset clears the stage valid bits only, datapath registers are not reset
// depends on gdn_pkg, gdn_date_to_day and gdn_day_to_date
`timescale 1ns / 1ps

module gregorian_day_number_converter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  gdn_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output gdn_pkg::rsp_word_type rsp_word
);

   localparam int NS = gdn_pkg::NUM_STAGES;

   // per-stage valid bits and the operation code that travels with each word
   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_in;
   logic [NS-1:0] func_ff;

   // stage i may load when it is empty or its word moves on this cycle
   logic [NS:0]           rdy;
   gdn_pkg::stage_en_type stage_en;

   // results of the two datapaths, both registered in their last stage
   logic [22:0] d2d_day_number;
   logic [2:0]  d2d_weekday;
   logic        d2d_error;
   logic [13:0] d2c_year;
   logic [3:0]  d2c_month;
   logic [4:0]  d2c_mday;
   logic        d2c_error;

   // ready chain from the output back to the input
   always_comb begin
      rdy[NS] = rsp_ready;
      for (int i = NS - 1; i >= 0; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
   end

   // a stage loads only when a word is arriving into it
   always_comb begin
      stage_en[0] = rdy[0] && req_valid;
      v_in[0]     = rdy[0] ? req_valid : v_ff[0];
      for (int i = 1; i < NS; i++) begin
         stage_en[i] = rdy[i] && v_ff[i-1];
         v_in[i]     = rdy[i] ? v_ff[i-1] : v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // operation code follows the word down the pipe
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         func_ff[0] <= req_word.func;
      end
      for (int i = 1; i < NS; i++) begin
         if (stage_en[i]) begin
            func_ff[i] <= func_ff[i-1];
         end
      end
   end

   assign req_ready = rdy[0];
   assign rsp_valid = v_ff[NS-1];

   // both datapaths see every word; the operation code picks the result
   gdn_date_to_day u_date_to_day (
      .clock      (clock),
      .stage_en   (stage_en),
      .year       (req_word.year_in),
      .month      (req_word.month_in),
      .mday       (req_word.mday_in),
      .day_number (d2d_day_number),
      .weekday    (d2d_weekday),
      .error      (d2d_error)
   );

   gdn_day_to_date u_day_to_date (
      .clock      (clock),
      .stage_en   (stage_en),
      .day_number (req_word.day_number_in),
      .year       (d2c_year),
      .month      (d2c_month),
      .mday       (d2c_mday),
      .error      (d2c_error)
   );

   // output select: fields of the other operation read as zero
   always_comb begin
      rsp_word = '0;
      if (func_ff[NS-1] == gdn_pkg::FUNC_TO_DAY) begin
         rsp_word.day_number_out = d2d_day_number;
         rsp_word.weekday_out    = d2d_weekday;
         rsp_word.error          = d2d_error;
      end else begin
         rsp_word.year_out  = d2c_year;
         rsp_word.month_out = d2c_month;
         rsp_word.mday_out  = d2c_mday;
         rsp_word.error     = d2c_error;
      end
   end

`ifndef SYNTHESIS
   // an accepted word always occupies the first stage next cycle
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v_ff[0])
      else $error("accepted word did not enter the first stage");

   // a result held by the sink stays put with its operation code
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      v_ff[NS-1] && !rsp_ready |=> v_ff[NS-1] && $stable(func_ff[NS-1]))
      else $error("stalled result was lost or changed operation");

   // date to day number leaves the date fields clear and a real weekday
   a_to_day_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && func_ff[NS-1] == gdn_pkg::FUNC_TO_DAY |->
         rsp_word.year_out == 14'd0 && rsp_word.month_out == 4'd0 &&
         rsp_word.mday_out == 5'd0 && rsp_word.weekday_out != 3'd0)
      else $error("date to day number result has bad fields");

   // an early year reports day zero, which falls on weekday one
   a_early_year: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && func_ff[NS-1] == gdn_pkg::FUNC_TO_DAY && rsp_word.error |->
         rsp_word.day_number_out == 23'd0 && rsp_word.weekday_out == 3'd1)
      else $error("early year result is not day zero");

   // a good day number always decodes to a real month and day, with the day number field clear
   a_to_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && func_ff[NS-1] == gdn_pkg::FUNC_TO_DATE && !rsp_word.error |->
         rsp_word.month_out >= 4'd1 && rsp_word.month_out <= 4'd12 &&
         rsp_word.mday_out >= 5'd1 && rsp_word.day_number_out == 23'd0)
      else $error("day number to date result out of range");
`endif

endmodule
